// ===== sv/epp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_pkg
// Shared types, constants and fixed-point helpers for the pose transform.
// ----------------------------------------------------------------------------
package epp_pkg;

    localparam int CordicSteps = 20;
    localparam int StepW       = 5;

    localparam logic signed [17:0] Q13Pi     = 18'sd25736;
    localparam logic signed [17:0] Q13TwoPi  = 18'sd51472;
    localparam logic signed [17:0] Q13HalfPi = 18'sd12868;
    localparam logic signed [33:0] CordicGain = 34'sd652032874;

    // Register indexes of the configuration port
    localparam logic [2:0] RegYaw   = 3'd0;
    localparam logic [2:0] RegPitch = 3'd1;
    localparam logic [2:0] RegRoll  = 3'd2;
    localparam logic [2:0] RegOffX  = 3'd3;
    localparam logic [2:0] RegOffY  = 3'd4;
    localparam logic [2:0] RegOffZ  = 3'd5;

    // Rotation matrix, row major, Q1.15 entries
    typedef logic [8:0][15:0] t_mat;
    typedef logic [2:0][31:0] t_vec;

    // Arctangent table in units of 2^-24 rad
    function automatic logic signed [31:0] atan_q24(input logic [StepW-1:0] i);
        logic signed [31:0] v;
        case (i)
            5'd0:    v = 32'sd13176795;
            5'd1:    v = 32'sd7778716;
            5'd2:    v = 32'sd4110060;
            5'd3:    v = 32'sd2086331;
            5'd4:    v = 32'sd1047214;
            5'd5:    v = 32'sd524117;
            5'd6:    v = 32'sd262123;
            5'd7:    v = 32'sd131069;
            5'd8:    v = 32'sd65536;
            5'd9:    v = 32'sd32768;
            5'd10:   v = 32'sd16384;
            5'd11:   v = 32'sd8192;
            5'd12:   v = 32'sd4096;
            5'd13:   v = 32'sd2048;
            5'd14:   v = 32'sd1024;
            5'd15:   v = 32'sd512;
            5'd16:   v = 32'sd256;
            5'd17:   v = 32'sd128;
            5'd18:   v = 32'sd64;
            5'd19:   v = 32'sd32;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    // Q1.15 product with round half up
    function automatic logic signed [19:0] mul15(input logic signed [17:0] a,
                                                 input logic signed [17:0] b);
        logic signed [35:0] p;
        p = a * b + 36'sd16384;
        return p[34:15];
    endfunction

    // Clamp to the Q1.15 range
    function automatic logic signed [15:0] clamp16(input logic signed [19:0] v);
        logic signed [15:0] r;
        if (v > 20'sd32767)       r = 16'sh7fff;
        else if (v < -20'sd32768) r = 16'sh8000;
        else                      r = v[15:0];
        return r;
    endfunction

endpackage

// ===== sv/epp_pose.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_pose
// Iterative CORDIC sine/cosine of the three angles and build of the matrix.
// ----------------------------------------------------------------------------
module epp_pose (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [2:0][15:0]   i_angle,   // yaw, pitch, roll
    output logic               o_busy,
    output epp_pkg::t_mat      o_mat
);
    import epp_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_LOAD = 5'b00010,
        S_ITER = 5'b00100,
        S_MAT1 = 5'b01000,
        S_MAT2 = 5'b10000
    } t_state;

    t_state             r_state;
    logic [1:0]         r_sel;
    logic [StepW-1:0]   r_step;
    logic               r_neg;
    logic signed [33:0] r_x, r_y;
    logic signed [31:0] r_z;
    logic signed [15:0] r_sin [3];
    logic signed [15:0] r_cos [3];
    logic signed [19:0] r_p [10];
    t_mat               r_mat;

    logic signed [17:0] a0, a1, a2;
    logic               n_neg;
    logic signed [33:0] dx, dy, xf, yf, xn, yn;
    logic signed [33:0] rs, rc;
    logic signed [17:0] sy, cy, sp, cp, sr, cr;

    // Range reduction to +-pi, then fold to +-pi/2
    always_comb begin
        a0 = 18'(signed'(i_angle[r_sel]));
        if (a0 > Q13Pi)       a1 = a0 - Q13TwoPi;
        else if (a0 < -Q13Pi) a1 = a0 + Q13TwoPi;
        else                  a1 = a0;
        n_neg = 1'b1;
        if (a1 > Q13HalfPi)       a2 = a1 - Q13Pi;
        else if (a1 < -Q13HalfPi) a2 = a1 + Q13Pi;
        else begin
            a2    = a1;
            n_neg = 1'b0;
        end
    end

    // One CORDIC micro-rotation, plus final sign fix and rounding
    always_comb begin
        dx = r_y >>> r_step;
        dy = r_x >>> r_step;
        xf = r_x + ((r_z >= 0) ? -dx : dx);
        yf = r_y + ((r_z >= 0) ? dy : -dy);
        xn = r_neg ? -xf : xf;
        yn = r_neg ? -yf : yf;
        rs = (yn + 34'sd16384) >>> 15;
        rc = (xn + 34'sd16384) >>> 15;
    end

    assign sy = 18'(r_sin[0]);
    assign cy = 18'(r_cos[0]);
    assign sp = 18'(r_sin[1]);
    assign cp = 18'(r_cos[1]);
    assign sr = 18'(r_sin[2]);
    assign cr = 18'(r_cos[2]);

    // Sequence the three angles, then two matrix passes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_sel   <= '0;
            r_step  <= '0;
        end else if (i_start) begin
            r_state <= S_LOAD;
            r_sel   <= '0;
        end else begin
            case (r_state)
                S_IDLE: r_state <= S_IDLE;
                S_LOAD: begin
                    r_state <= S_ITER;
                    r_step  <= '0;
                end
                S_ITER: begin
                    if (r_step == StepW'(CordicSteps - 1)) begin
                        if (r_sel == 2'd2) begin
                            r_state <= S_MAT1;
                        end else begin
                            r_state <= S_LOAD;
                            r_sel   <= r_sel + 2'd1;
                        end
                    end else begin
                        r_step <= r_step + 1'b1;
                    end
                end
                S_MAT1: r_state <= S_MAT2;
                S_MAT2: r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // Datapath registers
    always_ff @(posedge i_clk) begin
        if (r_state == S_LOAD) begin
            r_x   <= CordicGain;
            r_y   <= '0;
            r_z   <= 32'(a2) <<< 11;
            r_neg <= n_neg;
        end
        if (r_state == S_ITER) begin
            r_x <= xf;
            r_y <= yf;
            r_z <= (r_z >= 0) ? r_z - atan_q24(r_step) : r_z + atan_q24(r_step);
            if (r_step == StepW'(CordicSteps - 1)) begin
                r_sin[r_sel] <= clamp16(rs[19:0]);
                r_cos[r_sel] <= clamp16(rc[19:0]);
            end
        end
        if (r_state == S_MAT1) begin
            r_p[0] <= mul15(sy, sp);
            r_p[1] <= mul15(cy, sp);
            r_p[2] <= mul15(cy, cr);
            r_p[3] <= mul15(sy, cp);
            r_p[4] <= mul15(cy, sr);
            r_p[5] <= mul15(sy, cr);
            r_p[6] <= mul15(cy, cp);
            r_p[7] <= mul15(sy, sr);
            r_p[8] <= mul15(cp, sr);
            r_p[9] <= mul15(cp, cr);
        end
        if (r_state == S_MAT2) begin
            r_mat[0] <= clamp16(r_p[2] - mul15(r_p[0][17:0], sr));
            r_mat[1] <= clamp16(-r_p[3]);
            r_mat[2] <= clamp16(r_p[4] + mul15(r_p[0][17:0], cr));
            r_mat[3] <= clamp16(r_p[5] + mul15(r_p[1][17:0], sr));
            r_mat[4] <= clamp16(r_p[6]);
            r_mat[5] <= clamp16(r_p[7] - mul15(r_p[1][17:0], cr));
            r_mat[6] <= clamp16(-r_p[8]);
            r_mat[7] <= r_sin[1];
            r_mat[8] <= clamp16(r_p[9]);
        end
    end

    assign o_busy = i_start || (r_state != S_IDLE);
    assign o_mat  = r_mat;

    a_sel_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_sel != 2'd3) else $error("angle select out of range");
    a_mat_after_iter: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MAT1) |-> $past(r_sel) == 2'd2) else $error("matrix too early");
    a_busy_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_start |=> o_busy) else $error("not busy after start");

endmodule

// ===== sv/epp_mac.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// epp_mac
// Three-stage matrix-vector multiply, rounding, offset and saturation.
// ----------------------------------------------------------------------------
module epp_mac (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_valid,
    output logic            o_ready,
    input  epp_pkg::t_vec   i_point,
    input  epp_pkg::t_mat   i_mat,
    input  epp_pkg::t_vec   i_off,
    output logic            o_valid,
    input  logic            i_ready,
    output epp_pkg::t_vec   o_point
);
    import epp_pkg::*;

    logic               r_v1, r_v2, r_v3;
    logic signed [47:0] r_prod [9];
    logic signed [49:0] r_sum  [3];
    t_vec               r_out;
    logic               adv1, adv2, adv3;
    logic signed [49:0] rnd [3];
    logic signed [35:0] tot [3];
    t_vec               n_out;

    // Each stage moves when it is empty or the next one moves
    assign adv3    = !r_v3 || i_ready;
    assign adv2    = !r_v2 || adv3;
    assign adv1    = !r_v1 || adv2;
    assign o_ready = adv1;

    // Round, add offset, saturate
    always_comb begin
        for (int k = 0; k < 3; k++) begin
            rnd[k] = (r_sum[k] + 50'sd16384) >>> 15;
            tot[k] = rnd[k][35:0] + 36'(signed'(i_off[k]));
            if (tot[k] > 36'sh07fffffff)       n_out[k] = 32'h7fffffff;
            else if (tot[k] < -36'sh080000000) n_out[k] = 32'h80000000;
            else                               n_out[k] = tot[k][31:0];
        end
    end

    // Valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
        end else begin
            if (adv1) r_v1 <= i_valid;
            if (adv2) r_v2 <= r_v1;
            if (adv3) r_v3 <= r_v2;
        end
    end

    // Products, row sums, output
    always_ff @(posedge i_clk) begin
        if (adv1) begin
            for (int k = 0; k < 9; k++) begin
                r_prod[k] <= signed'(i_mat[k]) * signed'(i_point[k % 3]);
            end
        end
        if (adv2) begin
            for (int k = 0; k < 3; k++) begin
                r_sum[k] <= 50'(r_prod[3*k]) + 50'(r_prod[3*k+1]) + 50'(r_prod[3*k+2]);
            end
        end
        if (adv3) r_out <= n_out;
    end

    assign o_valid = r_v3;
    assign o_point = r_out;

    a_hold_mid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v2 && r_v3 && !i_ready) |=> r_v2) else $error("stage two lost an item");
    a_no_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!i_ready && !i_valid) |=> $countones({r_v1, r_v2, r_v3}) ==
        $past($countones({r_v1, r_v2, r_v3}))) else $error("item count changed");
    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_v1 && r_v2 && r_v3 && !i_ready) |-> !o_ready) else $error("overrun");

endmodule

// ===== sv/euler_pose_point_transform_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// euler_pose_point_transform_top
// Rotates each 3-D point by the yaw/pitch/roll matrix and adds the offset.
// ----------------------------------------------------------------------------
// Takes one point per clock, unless output back-pressure or a matrix rebuild
// holds it off, and passes it through a three-stage multiply/sum/saturate
// pipeline. After reset and after each write of an angle register the matrix
// is rebuilt by a single iterative CORDIC, run once per angle, and two matrix
// passes; s_axis_tready stays low meanwhile. Offset writes take effect at once.
module euler_pose_point_transform_top (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_addr,
    input  logic [31:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [95:0] s_axis_tdata,   // point_x, point_y, point_z
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [95:0] m_axis_tdata    // out_x, out_y, out_z
);
    import epp_pkg::*;

    logic [2:0][15:0] r_angle;
    t_vec             r_off;
    logic             r_start;
    logic             pose_busy;
    logic             mac_ready;
    t_mat             mat;
    t_vec             in_pt, out_pt;

    // Configuration registers; angle writes restart the matrix build
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_angle <= '0;
            r_off   <= '0;
            r_start <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                RegYaw: begin
                    r_angle[0] <= i_cfg_wdata[15:0];
                    r_start    <= 1'b1;
                end
                RegPitch: begin
                    r_angle[1] <= i_cfg_wdata[15:0];
                    r_start    <= 1'b1;
                end
                RegRoll: begin
                    r_angle[2] <= i_cfg_wdata[15:0];
                    r_start    <= 1'b1;
                end
                RegOffX: begin
                    r_off[0] <= i_cfg_wdata;
                    r_start  <= 1'b0;
                end
                RegOffY: begin
                    r_off[1] <= i_cfg_wdata;
                    r_start  <= 1'b0;
                end
                RegOffZ: begin
                    r_off[2] <= i_cfg_wdata;
                    r_start  <= 1'b0;
                end
                default: r_start <= 1'b0;
            endcase
        end else begin
            r_start <= 1'b0;
        end
    end

    epp_pose u_pose (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (r_start),
        .i_angle (r_angle),
        .o_busy  (pose_busy),
        .o_mat   (mat)
    );

    assign in_pt = s_axis_tdata;

    epp_mac u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (s_axis_tvalid && !pose_busy),
        .o_ready (mac_ready),
        .i_point (in_pt),
        .i_mat   (mat),
        .i_off   (r_off),
        .o_valid (m_axis_tvalid),
        .i_ready (m_axis_tready),
        .o_point (out_pt)
    );

    // Hold off input while the matrix is rebuilt
    assign s_axis_tready = mac_ready && !pose_busy;
    assign m_axis_tdata  = out_pt;

endmodule
